### rtl/core/qwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwd_pkg: shared types and codes for the quality weighted damper
// Outcome codes, register indexes, the weight unity constant and the
// per-request flag struct that travels down the pipeline.
// ----------------------------------------------------------------------------
package qwd_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_QUALITY_START = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_SLOPE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_CUT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CODE      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_NODATA        = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNDETECT      = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_OUT_UNDETECT  = 3'd6;

  // result outcome codes
  localparam logic [1:0] OUT_PASS   = 2'd0;
  localparam logic [1:0] OUT_LOWQ   = 2'd1;
  localparam logic [1:0] OUT_BELOW  = 2'd2;
  localparam logic [1:0] OUT_DAMPED = 2'd3;

  // weight of 1.0 in Q16
  localparam logic [16:0] W_ONE = 17'h10000;

  typedef struct packed {
    logic marker;     // data code is nodata or undetect
    logic low_q;      // weight below cut
    logic below_min;  // data below minimum
  } qwd_flags_t;

endpackage

### rtl/core/qwd_damp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qwd_damp_out: final add, round and saturate
// Adds the minimum offset and the half-LSB to the damped product, clamps
// to the code range and picks the result code by priority of the flags.
// ----------------------------------------------------------------------------
module qwd_damp_out #(
  parameter int unsigned DATA_BITS = 8,
  parameter int unsigned PV_W      = 34
) (
  input  qwd_pkg::qwd_flags_t   flags,
  input  logic [DATA_BITS-1:0]  data_code,
  input  logic [PV_W-1:0]       prod_v,
  input  logic [16:0]           min_code_q8,
  input  logic [7:0]            out_undetect_code,
  output logic [DATA_BITS-1:0]  out_code,
  output logic [1:0]            outcome
);
  import qwd_pkg::*;

  localparam int unsigned V_W = PV_W + 2;

  logic signed [V_W-1:0] min_term;
  logic signed [V_W-1:0] half_term;
  logic signed [V_W-1:0] sum_v;
  logic [DATA_BITS-1:0]  damped;

  assign min_term  = $signed({{(V_W-33){min_code_q8[16]}}, min_code_q8, 16'h0000});
  assign half_term = $signed({{(V_W-24){1'b0}}, 1'b1, 23'h000000});
  assign sum_v     = min_term + $signed({2'b00, prod_v}) + half_term;

  always_comb begin
    if (sum_v[V_W-1]) begin
      damped = '0;
    end else if (|sum_v[V_W-2:24+DATA_BITS]) begin
      damped = '1;
    end else begin
      damped = sum_v[24+DATA_BITS-1:24];
    end
  end

  always_comb begin
    if (flags.marker) begin
      out_code = data_code;
      outcome  = OUT_PASS;
    end else if (flags.low_q) begin
      out_code = DATA_BITS'(out_undetect_code);
      outcome  = OUT_LOWQ;
    end else if (flags.below_min) begin
      out_code = DATA_BITS'(out_undetect_code);
      outcome  = OUT_BELOW;
    end else begin
      out_code = damped;
      outcome  = OUT_DAMPED;
    end
  end

endmodule

### rtl/core/quality_weighted_damper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quality_weighted_damper: damps a coded data pixel by its quality weight
//
// Input channel: in_valid / in_stall carry one request, a data code and its
// quality code. A request is taken at a clock edge with in_valid high and
// in_stall low. Result channel: out_valid / out_stall carry out_code and
// out_outcome (pass marker, low quality, below minimum, damped).
// Configuration: cfg_we writes cfg_data into register cfg_index at the
// clock edge; write only while no request is in flight.
// Pipeline: a request taken at the input passes through four internal
// stages and then the output register, the first stage loaded at the edge
// that takes the request.
// Throughput: one request per clock while out_stall is low; the two
// multipliers (quality times slope, offset times weight) each own a stage.
// Stall: each stage moves when the one after it is empty or moving, so
// bubbles close up behind a stalled result and in_stall rises only once
// every stage holds a request.
// Reset: rst_n low (synchronous) empties the pipeline and loads register
// defaults.
// ----------------------------------------------------------------------------
module quality_weighted_damper #(
  parameter int unsigned DATA_BITS    = 8,
  parameter int unsigned QUALITY_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config
  input  logic                              cfg_we,
  input  logic [qwd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [qwd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [DATA_BITS-1:0]              in_data_code,
  input  logic [QUALITY_BITS-1:0]           in_quality_code,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [DATA_BITS-1:0]              out_code,
  output logic [1:0]                        out_outcome
);
  import qwd_pkg::*;

  // quality offset and data offset, signed Q.8
  localparam int unsigned DQ_W = QUALITY_BITS + 10;
  localparam int unsigned DX_W = DATA_BITS + 10;
  // weight product (before >> 8) and damped product
  localparam int unsigned PW_W = DQ_W - 1 + 24;
  localparam int unsigned PV_W = DX_W - 1 + 17;

  // ---------------- configuration registers ----------------
  logic [16:0] quality_start_r;
  logic [23:0] weight_slope_r;
  logic [16:0] weight_cut_r;
  logic [16:0] min_code_r;
  logic [7:0]  nodata_r;
  logic [7:0]  undetect_r;
  logic [7:0]  out_undetect_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_start_r <= 17'd32768;
      weight_slope_r  <= 24'd1049;
      weight_cut_r    <= 17'd0;
      min_code_r      <= 17'd0;
      nodata_r        <= 8'd255;
      undetect_r      <= 8'd0;
      out_undetect_r  <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUALITY_START: quality_start_r <= cfg_data[16:0];
        REG_WEIGHT_SLOPE:  weight_slope_r  <= cfg_data[23:0];
        REG_WEIGHT_CUT:    weight_cut_r    <= cfg_data[16:0];
        REG_MIN_CODE:      min_code_r      <= cfg_data[16:0];
        REG_NODATA:        nodata_r        <= cfg_data[7:0];
        REG_UNDETECT:      undetect_r      <= cfg_data[7:0];
        REG_OUT_UNDETECT:  out_undetect_r  <= cfg_data[7:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  // stage k advances when it is empty or its successor advances
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // ---------------- stage 1: offsets and marker test ----------------
  logic signed [DQ_W-1:0] dq_nxt;
  logic signed [DX_W-1:0] dx_nxt;
  qwd_flags_t             fl1_nxt;

  logic [DATA_BITS-1:0]   x1_r;
  logic signed [DQ_W-1:0] dq1_r;
  logic signed [DX_W-1:0] dx1_r;
  qwd_flags_t             fl1_r;

  assign dq_nxt = $signed({2'b00, in_quality_code, 8'h00})
                - $signed({{(DQ_W-17){quality_start_r[16]}}, quality_start_r});
  assign dx_nxt = $signed({2'b00, in_data_code, 8'h00})
                - $signed({{(DX_W-17){min_code_r[16]}}, min_code_r});

  always_comb begin
    fl1_nxt.marker    = (in_data_code == DATA_BITS'(nodata_r))
                     || (in_data_code == DATA_BITS'(undetect_r));
    fl1_nxt.low_q     = 1'b0;
    fl1_nxt.below_min = dx_nxt[DX_W-1];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r  <= in_data_code;
      dq1_r <= dq_nxt;
      dx1_r <= dx_nxt;
      fl1_r <= fl1_nxt;
    end
  end

  // ---------------- stage 2: quality offset times slope ----------------
  logic [DQ_W-2:0]        dq_pos;
  logic [PW_W-1:0]        prod_w2_r;
  logic [DATA_BITS-1:0]   x2_r;
  logic signed [DX_W-1:0] dx2_r;
  qwd_flags_t             fl2_r;

  // non-positive offset gives zero weight
  assign dq_pos = (!dq1_r[DQ_W-1] && (|dq1_r)) ? dq1_r[DQ_W-2:0] : '0;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      prod_w2_r <= dq_pos * weight_slope_r;
      x2_r      <= x1_r;
      dx2_r     <= dx1_r;
      fl2_r     <= fl1_r;
    end
  end

  // ---------------- stage 3: saturate weight, cut test ----------------
  logic [16:0]            w_c;
  qwd_flags_t             fl3_nxt;
  logic [16:0]            w3_r;
  logic [DATA_BITS-1:0]   x3_r;
  logic signed [DX_W-1:0] dx3_r;
  qwd_flags_t             fl3_r;

  always_comb begin
    if ((|prod_w2_r[PW_W-1:25]) || (prod_w2_r[24:8] > W_ONE)) begin
      w_c = W_ONE;
    end else begin
      w_c = prod_w2_r[24:8];
    end
    fl3_nxt       = fl2_r;
    fl3_nxt.low_q = (w_c < weight_cut_r);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      w3_r  <= w_c;
      x3_r  <= x2_r;
      dx3_r <= dx2_r;
      fl3_r <= fl3_nxt;
    end
  end

  // ---------------- stage 4: data offset times weight ----------------
  logic [PV_W-1:0]      prod_v4_r;
  logic [DATA_BITS-1:0] x4_r;
  qwd_flags_t           fl4_r;

  // a negative offset is overridden by the below-minimum flag
  always_ff @(posedge clk) begin
    if (rdy4) begin
      prod_v4_r <= dx3_r[DX_W-2:0] * w3_r;
      x4_r      <= x3_r;
      fl4_r     <= fl3_r;
    end
  end

  // ---------------- stage 5: round, saturate, output register ----------------
  logic [DATA_BITS-1:0] code_nxt;
  logic [1:0]           outcome_nxt;
  logic [DATA_BITS-1:0] out_code_r;
  logic [1:0]           out_outcome_r;

  qwd_damp_out #(
    .DATA_BITS (DATA_BITS),
    .PV_W      (PV_W)
  ) u_damp_out (
    .flags             (fl4_r),
    .data_code         (x4_r),
    .prod_v            (prod_v4_r),
    .min_code_q8       (min_code_r),
    .out_undetect_code (out_undetect_r),
    .out_code          (code_nxt),
    .outcome           (outcome_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_code_r    <= code_nxt;
      out_outcome_r <= outcome_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_code    = out_code_r;
  assign out_outcome = out_outcome_r;

  // ---------------- assertions ----------------
  // input backs up only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled with a free stage");

  // an accepted request lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted request lost at stage 1");

  // weight never exceeds unity
  a_weight_sat: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (w3_r <= W_ONE))
    else $error("weight above 1.0");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!v1_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule
